### rtl/bsc_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the bijective base-k string counter
// no dependencies

package bsc_pkg;

	// sizes fixed by the field widths
	localparam int MAX_LEN_DEF   = 16;
	localparam int MAX_CHARSET   = 56;
	localparam int DIGIT_W       = 6;
	localparam int CHAR_W        = 8;
	localparam int CS_WORDS      = 7;
	localparam int CS_WORD_W     = 64;
	localparam int CFG_IDX_W     = 3;
	localparam int START_LEN_W   = 5;
	localparam int AMOUNT_W      = 32;
	localparam int POSITION_W    = 4;
	localparam int STR_LEN_W     = 5;

	// running carry: amount plus one stale digit per position stays below 2^33
	localparam int N_W           = 33;
	localparam int DIV_BITS      = 3;
	localparam int DIV_STEPS     = N_W / DIV_BITS;
	localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

	// request codes
	localparam logic REQ_START   = 1'b0;
	localparam logic REQ_ADVANCE = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CHARSET_SIZE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WORD_BASE    = 3'd1;

	localparam logic [DIGIT_W-1:0] CHARSET_SIZE_RST = 6'd26;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef struct packed {
		logic clear;
		logic we;
	} dig_cmd_t;

endpackage

### rtl/bsc_div.sv
`timescale 1ns / 1ps
// shared divider: running carry divided by the radix, DIV_BITS quotient bits a cycle
// depends on bsc_pkg

module bsc_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [bsc_pkg::N_W-1:0]         dividend,
	input  logic [bsc_pkg::DIGIT_W-1:0]     divisor,
	output bsc_pkg::div_stat_t              stat,
	output logic [bsc_pkg::N_W-1:0]         quot,
	output logic [bsc_pkg::DIGIT_W-1:0]     rem
);
	import bsc_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [N_W-1:0]       sh_q;
	logic [DIGIT_W-1:0]   rem_q;
	logic [DIGIT_W-1:0]   div_q;

	logic [DIGIT_W-1:0]   rem_nx;
	logic [DIV_BITS-1:0]  qbits;

	// dividend bits leave at the top, quotient bits enter at the bottom
	always_comb begin
		logic [DIGIT_W:0] t;
		rem_nx = rem_q;
		qbits  = '0;
		for (int b = 0; b < DIV_BITS; b++) begin
			t = {rem_nx, sh_q[N_W-1-b]};
			if (t >= {1'b0, div_q}) begin
				t = t - {1'b0, div_q};
				qbits[DIV_BITS-1-b] = 1'b1;
			end
			rem_nx = t[DIGIT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			sh_q  <= {sh_q[N_W-DIV_BITS-1:0], qbits};
			rem_q <= rem_nx;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = sh_q;
	assign rem       = rem_q;

endmodule

### rtl/bsc_digits.sv
`timescale 1ns / 1ps
// digit store, least significant digit at index 0; entries without a valid bit read as zero
// depends on bsc_pkg

module bsc_digits #(
	parameter int DEPTH = bsc_pkg::MAX_LEN_DEF,
	parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bsc_pkg::dig_cmd_t           cmd,
	input  logic [IDX_W-1:0]            waddr,
	input  logic [bsc_pkg::DIGIT_W-1:0] wdata,
	input  logic [IDX_W-1:0]            raddr,
	output logic [bsc_pkg::DIGIT_W-1:0] rdata
);
	import bsc_pkg::*;

	logic [DEPTH-1:0]   valid_q;
	logic [DIGIT_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.clear) begin
			valid_q <= '0;
		end else if (cmd.we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.we) begin
			mem_q[waddr] <= wdata;
		end
	end

	assign rdata = valid_q[raddr] ? mem_q[raddr] : '0;

endmodule

### rtl/bijective_base_k_string_counter.sv
`timescale 1ns / 1ps
// Candidate string counter: a start request goes straight to output, while an advance request
// walks the digits from the least significant, finishing each directly while its running sum
// stays below the radix and otherwise through the shared 3-bit-per-cycle divider (11 steps);
// the string then leaves one character per beat. One item is worked at a time.
// depends on bsc_pkg, bsc_div, bsc_digits

module bijective_base_k_string_counter #(
	parameter int MAX_LEN = bsc_pkg::MAX_LEN_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// request channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               req_type,
	input  logic [bsc_pkg::AMOUNT_W-1:0]       amount,
	input  logic [bsc_pkg::START_LEN_W-1:0]    start_length,
	// character channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [bsc_pkg::POSITION_W-1:0]     position,
	output logic [bsc_pkg::CHAR_W-1:0]         char_code,
	output logic [bsc_pkg::DIGIT_W-1:0]        digit_value,
	output logic [bsc_pkg::STR_LEN_W-1:0]      string_length,
	output logic                               overflow,
	output logic                               last,
	// register writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bsc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bsc_pkg::CS_WORD_W-1:0]      cfg_data
);
	import bsc_pkg::*;

	localparam int LEN_W = $clog2(MAX_LEN + 1);
	localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_ADD  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	// registers
	logic [DIGIT_W-1:0]   cs_size_q;
	logic [CS_WORD_W-1:0] cs_word_q [CS_WORDS];

	// sequencer state
	state_t             state_q, state_d;
	logic [LEN_W-1:0]   len_q, len_d;
	logic               ovf_q, ovf_d;
	logic [N_W-1:0]     n_q, n_d;
	logic [IDX_W-1:0]   j_q, j_d;
	logic               fresh_q, fresh_d;
	logic [IDX_W-1:0]   i_q, i_d;

	// output register
	logic                  out_valid_q;
	logic [POSITION_W-1:0] position_q;
	logic [CHAR_W-1:0]     char_q;
	logic [DIGIT_W-1:0]    digit_q;
	logic [STR_LEN_W-1:0]  slen_q;
	logic                  ovf_out_q;
	logic                  last_q;

	logic [DIGIT_W-1:0] radix;
	logic [LEN_W-1:0]   start_len;
	logic [IDX_W-1:0]   emit_addr;
	logic [IDX_W-1:0]   rd_addr;
	logic [DIGIT_W-1:0] rd_digit;
	logic [DIGIT_W-1:0] add_digit;
	logic [N_W-1:0]     sum;
	logic               is_first;
	logic               emit_last;
	logic [CHAR_W-1:0]  rd_char;

	logic               fin;
	logic [DIGIT_W-1:0] fin_r;
	logic [N_W-1:0]     fin_q;
	logic               div_go;
	logic               emit_ld;

	div_stat_t          div_stat;
	logic [N_W-1:0]     div_quot;
	logic [DIGIT_W-1:0] div_rem;
	dig_cmd_t           dig_cmd;

	// register writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_size_q <= CHARSET_SIZE_RST;
			for (int w = 0; w < CS_WORDS; w++) begin
				cs_word_q[w] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_CHARSET_SIZE) begin
				cs_size_q <= cfg_data[DIGIT_W-1:0];
			end else begin
				cs_word_q[cfg_index - CFG_WORD_BASE] <= cfg_data;
			end
		end
	end

	// radix 0 counts as 1, too large clamps
	always_comb begin
		if (cs_size_q == '0) begin
			radix = DIGIT_W'(1);
		end else if (int'(cs_size_q) > MAX_CHARSET) begin
			radix = DIGIT_W'(MAX_CHARSET);
		end else begin
			radix = cs_size_q;
		end
	end

	always_comb begin
		if (start_length == '0) begin
			start_len = LEN_W'(1);
		end else if (int'(start_length) > MAX_LEN) begin
			start_len = LEN_W'(MAX_LEN);
		end else begin
			start_len = LEN_W'(start_length);
		end
	end

	// string position i lives at index len-1-i
	assign emit_addr = IDX_W'(len_q - LEN_W'(1) - LEN_W'(i_q));
	assign rd_addr   = (state_q == ST_EMIT) ? emit_addr : j_q;
	assign add_digit = fresh_q ? '0 : rd_digit;
	assign sum       = N_W'(add_digit) + n_q;
	assign is_first  = (LEN_W'(j_q) == len_q - LEN_W'(1));
	assign emit_last = (LEN_W'(i_q) == len_q - LEN_W'(1));

	always_comb begin
		if (int'(rd_digit) < MAX_CHARSET) begin
			rd_char = cs_word_q[rd_digit[DIGIT_W-1:3]][{rd_digit[2:0], 3'b000} +: CHAR_W];
		end else begin
			rd_char = '0;
		end
	end

	bsc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go),
		.dividend (sum),
		.divisor  (radix),
		.stat     (div_stat),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	bsc_digits #(
		.DEPTH (MAX_LEN),
		.IDX_W (IDX_W)
	) u_digits (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (dig_cmd),
		.waddr  (j_q),
		.wdata  (fin_r),
		.raddr  (rd_addr),
		.rdata  (rd_digit)
	);

	always_comb begin
		state_d = state_q;
		len_d   = len_q;
		ovf_d   = ovf_q;
		n_d     = n_q;
		j_d     = j_q;
		fresh_d = fresh_q;
		i_d     = i_q;
		fin     = 1'b0;
		fin_r   = div_rem;
		fin_q   = div_quot;
		div_go  = 1'b0;
		emit_ld = 1'b0;
		dig_cmd = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					i_d = '0;
					if (req_type == REQ_START) begin
						len_d         = start_len;
						ovf_d         = 1'b0;
						dig_cmd.clear = 1'b1;
						state_d       = ST_EMIT;
					end else begin
						n_d     = N_W'(amount);
						j_d     = '0;
						fresh_d = 1'b0;
						state_d = (amount == '0) ? ST_EMIT : ST_ADD;
					end
				end
			end
			ST_ADD: begin
				// sum already below the radix: no division needed
				if (sum < N_W'(radix)) begin
					fin   = 1'b1;
					fin_r = sum[DIGIT_W-1:0];
					fin_q = '0;
				end else begin
					div_go  = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				fin = div_stat.done;
			end
			ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					emit_ld = 1'b1;
					i_d     = i_q + IDX_W'(1);
					if (emit_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (fin) begin
			dig_cmd.we = 1'b1;
			if (is_first && fin_q != '0) begin
				if (len_q >= LEN_W'(MAX_LEN)) begin
					// no room to grow: drop the carry
					ovf_d   = 1'b1;
					state_d = ST_EMIT;
				end else begin
					// new leading digit starts at zero and takes carry minus one
					len_d   = len_q + LEN_W'(1);
					n_d     = fin_q - N_W'(1);
					j_d     = j_q + IDX_W'(1);
					fresh_d = 1'b1;
					state_d = (fin_q == N_W'(1)) ? ST_EMIT : ST_ADD;
				end
			end else begin
				n_d     = fin_q;
				j_d     = j_q + IDX_W'(1);
				fresh_d = 1'b0;
				state_d = (fin_q == '0) ? ST_EMIT : ST_ADD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q   <= LEN_W'(1);
			ovf_q   <= 1'b0;
			n_q     <= '0;
			j_q     <= '0;
			fresh_q <= 1'b0;
			i_q     <= '0;
		end else begin
			state_q <= state_d;
			len_q   <= len_d;
			ovf_q   <= ovf_d;
			n_q     <= n_d;
			j_q     <= j_d;
			fresh_q <= fresh_d;
			i_q     <= i_d;
		end
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_ld) begin
			position_q <= POSITION_W'(i_q);
			char_q     <= rd_char;
			digit_q    <= rd_digit;
			slen_q     <= STR_LEN_W'(len_q);
			ovf_out_q  <= ovf_q;
			last_q     <= emit_last;
		end
	end

	assign in_stall      = (state_q != ST_IDLE);
	assign out_valid     = out_valid_q;
	assign position      = position_q;
	assign char_code     = char_q;
	assign digit_value   = digit_q;
	assign string_length = slen_q;
	assign overflow      = ovf_out_q;
	assign last          = last_q;

	// divider only works and reports back while the sequencer waits for it
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		(div_stat.busy || div_stat.done) |-> state_q == ST_DIV)
		else $error("divider active outside wait state");

	// overflow may only appear on a full-length string
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovf_q) |-> len_q == LEN_W'(MAX_LEN))
		else $error("overflow raised below maximum length");

	// during an advance the string grows by at most one digit a cycle
	a_len_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD || state_q == ST_DIV) |=>
		(len_q == $past(len_q) || len_q == $past(len_q) + LEN_W'(1)))
		else $error("string length jumped");

endmodule

### tb/bsc_checker.sv
`timescale 1ns / 1ps
// scoreboard for the bijective base-k string counter: tracks register writes,
// predicts the character beats of every accepted request and compares them
// depends on bsc_pkg

module bsc_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic                               req_type,
	input  logic [bsc_pkg::AMOUNT_W-1:0]       amount,
	input  logic [bsc_pkg::START_LEN_W-1:0]    start_length,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic [bsc_pkg::POSITION_W-1:0]     position,
	input  logic [bsc_pkg::CHAR_W-1:0]         char_code,
	input  logic [bsc_pkg::DIGIT_W-1:0]        digit_value,
	input  logic [bsc_pkg::STR_LEN_W-1:0]      string_length,
	input  logic                               overflow,
	input  logic                               last,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [bsc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bsc_pkg::CS_WORD_W-1:0]      cfg_data,
	output int                                 errors,
	output int                                 pending
);
	import bsc_pkg::*;

	localparam int MAX_LEN = MAX_LEN_DEF;

	typedef struct {
		logic [POSITION_W-1:0] position;
		logic [CHAR_W-1:0]     char_code;
		logic [DIGIT_W-1:0]    digit_value;
		logic [STR_LEN_W-1:0]  string_length;
		logic                  overflow;
		logic                  last;
	} char_beat_t;

	logic [DIGIT_W-1:0]   cs_size;
	logic [CS_WORD_W-1:0] cs_word [CS_WORDS];
	logic [DIGIT_W-1:0]   digits [MAX_LEN];
	int                   cur_len;
	logic                 ovf;
	char_beat_t           char_queue [$];
	int                   err_cnt = 0;

	assign errors = err_cnt;

	function automatic int radix_now();
		int k;
		k = cs_size;
		if (k == 0)
			k = 1;
		if (k > MAX_CHARSET)
			k = MAX_CHARSET;
		return k;
	endfunction

	function automatic logic [CHAR_W-1:0] char_for(logic [DIGIT_W-1:0] dv);
		if (dv >= MAX_CHARSET)
			return '0;
		return cs_word[dv >> 3][(dv & 6'd7) * 8 +: 8];
	endfunction

	// ripple the amount in from the last digit, growing the string on carry out
	task automatic add_amount(input longint unsigned n);
		longint unsigned k;
		longint unsigned s;
		int d;
		k = radix_now();
		d = cur_len;
		while (n != 0) begin
			d--;
			s = digits[d] + n;
			digits[d] = DIGIT_W'(s % k);
			n = s / k;
			if (d == 0 && n != 0) begin
				if (cur_len >= MAX_LEN) begin
					// carry past the widest string is dropped
					ovf = 1'b1;
					n = 0;
				end else begin
					for (int j = cur_len; j > 0; j--)
						digits[j] = digits[j-1];
					digits[0] = '0;
					cur_len++;
					n--;
					d++;
				end
			end
		end
	endtask

	task automatic queue_string();
		char_beat_t b;
		for (int i = 0; i < cur_len; i++) begin
			b.position      = POSITION_W'(i);
			b.digit_value   = digits[i];
			b.char_code     = char_for(digits[i]);
			b.string_length = STR_LEN_W'(cur_len);
			b.overflow      = ovf;
			b.last          = (i + 1 == cur_len);
			char_queue.push_back(b);
		end
	endtask

	task automatic check_field(input string name, input logic [CHAR_W-1:0] want,
			input logic [CHAR_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		char_beat_t want;
		int len;
		if (!arst_n) begin
			cs_size = CHARSET_SIZE_RST;
			for (int i = 0; i < CS_WORDS; i++)
				cs_word[i] = '0;
			for (int i = 0; i < MAX_LEN; i++)
				digits[i] = '0;
			cur_len = 1;
			ovf = 1'b0;
			char_queue.delete();
			pending <= 0;
		end else begin
			if (out_valid === 1'b1 && out_stall == 1'b0) begin
				if (char_queue.size() == 0) begin
					$error("character beat at position %0d with nothing expected", position);
					err_cnt++;
				end else begin
					want = char_queue.pop_front();
					check_field("position", 8'(want.position), 8'(position));
					check_field("char_code", want.char_code, char_code);
					check_field("digit_value", 8'(want.digit_value), 8'(digit_value));
					check_field("string_length", 8'(want.string_length), 8'(string_length));
					check_field("overflow", 8'(want.overflow), 8'(overflow));
					check_field("last", 8'(want.last), 8'(last));
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_CHARSET_SIZE)
					cs_size = cfg_data[DIGIT_W-1:0];
				else
					cs_word[cfg_index - CFG_WORD_BASE] = cfg_data;
			end
			if (in_valid && !in_stall) begin
				if (req_type == REQ_START) begin
					len = start_length;
					if (len == 0)
						len = 1;
					if (len > MAX_LEN)
						len = MAX_LEN;
					for (int i = 0; i < MAX_LEN; i++)
						digits[i] = '0;
					cur_len = len;
					ovf = 1'b0;
				end else begin
					add_amount(amount);
				end
				queue_string();
			end
			pending <= char_queue.size();
		end
	end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// top of the string counter testbench: clock, reset, register writes, output back-pressure and
// request stimulus with random gaps; checking is done in bsc_checker
// depends on bsc_pkg, bijective_base_k_string_counter, bsc_checker

module tb;
	import bsc_pkg::*;

	localparam int LIMIT = 1000000;
	localparam int TAIL  = 300;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic                   req_type = REQ_START;
	logic [AMOUNT_W-1:0]    amount = '0;
	logic [START_LEN_W-1:0] start_length = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [POSITION_W-1:0]  position;
	logic [CHAR_W-1:0]      char_code;
	logic [DIGIT_W-1:0]     digit_value;
	logic [STR_LEN_W-1:0]   string_length;
	logic                   overflow;
	logic                   last;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CS_WORD_W-1:0]   cfg_data = '0;
	int                     errors;
	int                     pending;
	int                     cycles = 0;
	int                     stall_left = 0;
	bit                     calm = 1'b0;

	bijective_base_k_string_counter dut (.*);

	bsc_checker chk (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// receiver back-pressure in runs of random length
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else begin
			out_stall  <= calm ? 1'b0 : 1'($urandom_range(0, 1));
			stall_left <= gap_len();
		end
	end

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CS_WORD_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// valid may stay high from the previous beat when no gap is taken
	task automatic send_req(input logic rt, input logic [AMOUNT_W-1:0] amt,
			input logic [START_LEN_W-1:0] len);
		int gap;
		gap = calm ? 0 : gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		req_type     <= rt;
		amount       <= amt;
		start_length <= len;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic load_words(input bit ascii);
		logic [CS_WORD_W-1:0] w;
		for (int i = 0; i < CS_WORDS; i++) begin
			if (ascii) begin
				for (int b = 0; b < 8; b++)
					w[b*8 +: 8] = 8'(33 + i * 8 + b);
			end else begin
				w = {$urandom, $urandom};
			end
			cfg_write(CFG_WORD_BASE + CFG_IDX_W'(i), w);
		end
	endtask

	task automatic random_req();
		logic [AMOUNT_W-1:0] amt;
		if ($urandom_range(0, 4) == 0) begin
			// mostly short strings, a few clamped lengths
			if ($urandom_range(0, 9) == 0)
				send_req(REQ_START, $urandom, START_LEN_W'($urandom_range(0, 31)));
			else
				send_req(REQ_START, $urandom, START_LEN_W'($urandom_range(1, 6)));
		end else begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: amt = $urandom_range(0, 60);
				5, 6:          amt = $urandom_range(0, 65535);
				7:             amt = '1;
				default:       amt = $urandom;
			endcase
			send_req(REQ_ADVANCE, amt, START_LEN_W'($urandom));
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: radix 26, empty charset
		send_req(REQ_ADVANCE, 32'd1, 5'd0);
		send_req(REQ_ADVANCE, 32'd25, 5'd0);
		send_req(REQ_ADVANCE, 32'd0, 5'd0);
		send_req(REQ_START, 32'd0, 5'd3);
		drain();

		cfg_write(CFG_CHARSET_SIZE, 64'd56);
		load_words(1'b1);
		send_req(REQ_START, 32'd0, 5'd0);
		send_req(REQ_START, 32'd0, 5'd16);
		send_req(REQ_ADVANCE, '1, 5'd0);
		send_req(REQ_START, '1, 5'd31);
		send_req(REQ_START, 32'd0, 5'd17);
		send_req(REQ_ADVANCE, 32'd55, 5'd0);
		send_req(REQ_START, 32'd0, 5'd5);
		send_req(REQ_ADVANCE, '1, 5'd0);
		drain();

		// radix 2 over digits left from radix 56, then overflow and its clear
		cfg_write(CFG_CHARSET_SIZE, 64'd2);
		send_req(REQ_ADVANCE, 32'd1, 5'd0);
		send_req(REQ_START, 32'd0, 5'd16);
		send_req(REQ_ADVANCE, '1, 5'd0);
		send_req(REQ_ADVANCE, 32'd1, 5'd0);
		send_req(REQ_START, 32'd0, 5'd2);
		drain();

		cfg_write(CFG_CHARSET_SIZE, 64'd1);
		send_req(REQ_START, 32'd0, 5'd1);
		send_req(REQ_ADVANCE, 32'd3, 5'd0);
		send_req(REQ_ADVANCE, 32'd20, 5'd0);
		drain();

		// size zero acts as radix one with upper data bits ignored, sizes above 56 clamp
		cfg_write(CFG_CHARSET_SIZE, {58'h3FF_FFFF_FFFF_FFFF, 6'd0});
		send_req(REQ_ADVANCE, 32'd2, 5'd0);
		drain();
		cfg_write(CFG_CHARSET_SIZE, 64'd63);
		send_req(REQ_START, 32'd0, 5'd4);
		send_req(REQ_ADVANCE, '1, 5'd0);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0:       cfg_write(CFG_CHARSET_SIZE, 64'd56);
				1:       cfg_write(CFG_CHARSET_SIZE, 64'd2);
				2:       cfg_write(CFG_CHARSET_SIZE, 64'($urandom_range(3, 55)));
				3:       cfg_write(CFG_CHARSET_SIZE, 64'd1);
				4:       cfg_write(CFG_CHARSET_SIZE, $urandom_range(0, 1) ? 64'd63 : 64'd0);
				default: cfg_write(CFG_CHARSET_SIZE, {$urandom, $urandom});
			endcase
			load_words(1'b0);
			for (int n = 0; n < 35; n++) begin
				if ($urandom_range(0, 19) == 0)
					calm = ~calm;
				// sender holds off until the string counter has emptied
				if ($urandom_range(0, 39) == 0)
					drain();
				random_req();
			end
			drain();
		end

		calm = 1'b0;
		repeat (TAIL) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
